// ===== rtl/core/fcsp_pkg.sv =====
// Package: widths, register indexes and reset values for the four-channel speed PID.
`timescale 1ns / 1ps

package fcsp_pkg;

    // field widths
    localparam int MOTOR_W   = 2;
    localparam int SPEED_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int LIM_W     = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int FRAC_BITS = 8;

    // reset values
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RESET = 16'sd1280;
    localparam logic [LIM_W-1:0]         DEFAULT_LIMIT   = 15'd5000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN      = 3'd0,
        CFG_INTEG_GAIN     = 3'd1,
        CFG_DERIV_GAIN     = 3'd2,
        CFG_ERROR_LIMIT    = 3'd3,
        CFG_DEADBAND       = 3'd4,
        CFG_INTEGRAL_LIMIT = 3'd5,
        CFG_DRIVE_LIMIT    = 3'd6
    } t_cfg_idx;

    // configuration register set
    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic [LIM_W-1:0]         error_limit;
        logic [LIM_W-1:0]         deadband;
        logic [LIM_W-1:0]         integral_limit;
        logic [LIM_W-1:0]         drive_limit;
    } t_cfg;

endpackage

// ===== rtl/core/four_channel_speed_pid_unit.sv =====
// Top level: four-channel positional speed PID with deadband and clamps.
// A result word passes through the stage 0, stage 1, stage 2 and output registers.
// Throughput: one word per cycle unless the output word is stalled; per-motor state
// updates in stage 1, so words for the same motor may follow each other back to back.
// A stalled output word halts the whole four-register pipeline.
// Reset (synchronous, active low) clears valids and per-motor state and loads config registers with reset values.
`timescale 1ns / 1ps

module four_channel_speed_pid_unit #(
    parameter int NUM_MOTORS = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input words
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [fcsp_pkg::MOTOR_W-1:0]           i_motor_index,
    input  logic signed [fcsp_pkg::SPEED_W-1:0]    i_target_speed,
    input  logic signed [fcsp_pkg::SPEED_W-1:0]    i_measured_speed,
    // result words
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [fcsp_pkg::MOTOR_W-1:0]           o_drive_motor,
    output logic signed [fcsp_pkg::SPEED_W-1:0]    o_drive_value,
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [fcsp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [fcsp_pkg::CFG_DAT_W-1:0]         i_cfg_data
);
    import fcsp_pkg::*;

    localparam int SUM_W = 35;

    t_cfg r_cfg;

    // pipeline advance: everything moves unless the output word is stalled
    logic w_adv;
    assign w_adv       = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain      <= PROP_GAIN_RESET;
            r_cfg.integ_gain     <= '0;
            r_cfg.deriv_gain     <= '0;
            r_cfg.error_limit    <= DEFAULT_LIMIT;
            r_cfg.deadband       <= '0;
            r_cfg.integral_limit <= DEFAULT_LIMIT;
            r_cfg.drive_limit    <= DEFAULT_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PROP_GAIN:      r_cfg.prop_gain      <= $signed(i_cfg_data);
                CFG_INTEG_GAIN:     r_cfg.integ_gain     <= $signed(i_cfg_data);
                CFG_DERIV_GAIN:     r_cfg.deriv_gain     <= $signed(i_cfg_data);
                CFG_ERROR_LIMIT:    r_cfg.error_limit    <= i_cfg_data[LIM_W-1:0];
                CFG_DEADBAND:       r_cfg.deadband       <= i_cfg_data[LIM_W-1:0];
                CFG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_data[LIM_W-1:0];
                CFG_DRIVE_LIMIT:    r_cfg.drive_limit    <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: input register ----------------
    logic                      r_s0_valid;
    logic [MOTOR_W-1:0]        r_s0_motor;
    logic signed [SPEED_W-1:0] r_s0_tgt;
    logic signed [SPEED_W-1:0] r_s0_meas;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_in_valid) begin
            r_s0_motor <= i_motor_index;
            r_s0_tgt   <= i_target_speed;
            r_s0_meas  <= i_measured_speed;
        end
    end

    // ---------------- stage 1: error, integral, derivative ----------------
    logic signed [SPEED_W-1:0] r_integ_sum [NUM_MOTORS];
    logic signed [SPEED_W-1:0] r_prev_err  [NUM_MOTORS];

    logic                      w_in_range;
    logic signed [SPEED_W-1:0] w_old_integ;
    logic signed [SPEED_W-1:0] w_old_err;
    logic signed [SPEED_W:0]   w_diff;
    logic signed [SPEED_W:0]   w_elim;
    logic signed [SPEED_W:0]   w_eclamp;
    logic signed [SPEED_W:0]   w_db;
    logic signed [SPEED_W-1:0] w_err;
    logic signed [SPEED_W:0]   w_isum;
    logic signed [SPEED_W:0]   w_ilim;
    logic signed [SPEED_W-1:0] w_integ;
    logic signed [SPEED_W:0]   w_deriv;

    // per-motor state lookup
    always_comb begin
        w_in_range  = int'(r_s0_motor) < NUM_MOTORS;
        w_old_integ = '0;
        w_old_err   = '0;
        for (int k = 0; k < NUM_MOTORS; k++) begin
            if (int'(r_s0_motor) == k) begin
                w_old_integ = r_integ_sum[k];
                w_old_err   = r_prev_err[k];
            end
        end
    end

    // error clamp, deadband, integral clamp, derivative
    always_comb begin
        w_diff = SPEED_W'(0) + ({r_s0_tgt[SPEED_W-1], r_s0_tgt}
                              - {r_s0_meas[SPEED_W-1], r_s0_meas});
        w_elim = $signed({2'b00, r_cfg.error_limit});
        if (w_diff > w_elim) begin
            w_eclamp = w_elim;
        end else if (w_diff < -w_elim) begin
            w_eclamp = -w_elim;
        end else begin
            w_eclamp = w_diff;
        end
        w_db = $signed({2'b00, r_cfg.deadband});
        if ((w_eclamp > 0 && w_eclamp < w_db) || (w_eclamp < 0 && w_eclamp > -w_db)) begin
            w_err = '0;
        end else begin
            w_err = w_eclamp[SPEED_W-1:0];
        end
        // out-of-range motor: all terms zero, so the drive comes out zero
        if (!w_in_range) begin
            w_err = '0;
        end

        w_isum = {w_old_integ[SPEED_W-1], w_old_integ} + {w_err[SPEED_W-1], w_err};
        w_ilim = $signed({2'b00, r_cfg.integral_limit});
        if (w_isum > w_ilim) begin
            w_integ = w_ilim[SPEED_W-1:0];
        end else if (w_isum < -w_ilim) begin
            w_integ = SPEED_W'(-w_ilim);
        end else begin
            w_integ = w_isum[SPEED_W-1:0];
        end
        w_deriv = {w_err[SPEED_W-1], w_err} - {w_old_err[SPEED_W-1], w_old_err};
        if (!w_in_range) begin
            w_integ = '0;
            w_deriv = '0;
        end
    end

    // per-motor state update, once per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_MOTORS; k++) begin
                r_integ_sum[k] <= '0;
                r_prev_err[k]  <= '0;
            end
        end else if (w_adv && r_s0_valid) begin
            for (int k = 0; k < NUM_MOTORS; k++) begin
                if (int'(r_s0_motor) == k) begin
                    r_integ_sum[k] <= w_integ;
                    r_prev_err[k]  <= w_err;
                end
            end
        end
    end

    logic                      r_s1_valid;
    logic [MOTOR_W-1:0]        r_s1_motor;
    logic signed [SPEED_W-1:0] r_s1_err;
    logic signed [SPEED_W-1:0] r_s1_integ;
    logic signed [SPEED_W:0]   r_s1_deriv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s0_valid) begin
            r_s1_motor <= r_s0_motor;
            r_s1_err   <= w_err;
            r_s1_integ <= w_integ;
            r_s1_deriv <= w_deriv;
        end
    end

    // ---------------- stage 2: gain products ----------------
    logic                             r_s2_valid;
    logic [MOTOR_W-1:0]               r_s2_motor;
    logic signed [GAIN_W+SPEED_W-1:0] r_s2_pterm;
    logic signed [GAIN_W+SPEED_W-1:0] r_s2_iterm;
    logic signed [GAIN_W+SPEED_W:0]   r_s2_dterm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_s2_motor <= r_s1_motor;
            r_s2_pterm <= r_cfg.prop_gain * r_s1_err;
            r_s2_iterm <= r_cfg.integ_gain * r_s1_integ;
            r_s2_dterm <= r_cfg.deriv_gain * r_s1_deriv;
        end
    end

    // ---------------- stage 3: sum, truncate toward zero, saturate ----------------
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_quot;
    logic signed [SUM_W-1:0] w_dlim;
    logic signed [SPEED_W-1:0] w_drive;

    always_comb begin
        w_sum = SUM_W'(r_s2_pterm) + SUM_W'(r_s2_iterm) + SUM_W'(r_s2_dterm);
        // bias negative sums so the arithmetic shift rounds toward zero
        if (w_sum[SUM_W-1]) begin
            w_quot = (w_sum + SUM_W'((1 << FRAC_BITS) - 1)) >>> FRAC_BITS;
        end else begin
            w_quot = w_sum >>> FRAC_BITS;
        end
        w_dlim = $signed({{(SUM_W-LIM_W){1'b0}}, r_cfg.drive_limit});
        if (w_quot > w_dlim) begin
            w_drive = w_dlim[SPEED_W-1:0];
        end else if (w_quot < -w_dlim) begin
            w_drive = SPEED_W'(-w_dlim);
        end else begin
            w_drive = w_quot[SPEED_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_adv) begin
            o_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2_valid) begin
            o_drive_motor <= r_s2_motor;
            o_drive_value <= w_drive;
        end
    end

    // ---------------- assertions ----------------
    // per-motor state only moves when the pipeline advances
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_integ_sum[0]) && $stable(r_prev_err[0]))
        else $error("motor 0 state changed during a stall");

    // an accepted word lands in stage 0 with its motor index
    a_s0_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_s0_valid && r_s0_motor == $past(i_motor_index))
        else $error("accepted word missing from stage 0");

    // a new result word comes only from a valid stage 2 word
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s2_valid))
        else $error("result word without a stage 2 source");

    // stage 2 motor index reaches the output unchanged
    a_motor_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_s2_valid |=> o_out_valid && o_drive_motor == $past(r_s2_motor))
        else $error("drive motor does not follow its word");

endmodule
